### rtl/sdpl_pkg.sv
// Shared types, constants and helpers for the stereo delay peak limiter.
// No dependencies; every rtl module imports this package.
`default_nettype none

package sdpl_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 25;
	localparam int COEFF_W    = 24;
	localparam int THR_W      = 15;
	localparam int VOL_W      = 16;
	localparam int DELAY_W    = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int DIV_STEPS  = 24;
	localparam int DELAY_DEPTH_DEF = 2048;

	localparam logic [GAIN_W-1:0]  UNITY_GAIN  = 25'd16777216;
	localparam logic [VOL_W-1:0]   VOLUME_RST  = 16'd26214;
	localparam logic [DELAY_W-1:0] DELAY_RST   = 11'd0;
	localparam logic [THR_W-1:0]   THR_RST     = 15'd32112;
	localparam logic [COEFF_W-1:0] ATTACK_RST  = 24'd16401076;
	localparam logic [COEFF_W-1:0] RELEASE_RST = 24'd16773412;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;

	typedef struct packed {
		logic scale;
		logic write;
		logic read;
		logic rd_ok;
		logic outmul;
	} lane_ctl_t;

	// Magnitude of a 16-bit signed sample, 0..32768.
	function automatic logic [16:0] mag16(input logic signed [15:0] x);
		logic signed [16:0] e;
		e = {x[15], x};
		return x[15] ? 17'(-e) : 17'(e);
	endfunction

	// Apply sign to a truncated magnitude and clamp to 16 bits.
	function automatic logic signed [15:0] sat_mag(input logic neg, input logic [17:0] mag);
		logic signed [15:0] r;
		if (neg) begin
			if (mag > 18'd32768) r = 16'sh8000;
			else r = 16'(~mag[15:0] + 16'd1);
		end else begin
			if (mag > 18'd32767) r = 16'sh7fff;
			else r = 16'(mag[15:0]);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/sdpl_lane.sv
// One channel lane: volume scaling, ring delay memory and gain scaling.
// Depends on sdpl_pkg; sequenced by the top level through lane_ctl_t.
`default_nettype none

module sdpl_lane #(
	parameter int DELAY_DEPTH = sdpl_pkg::DELAY_DEPTH_DEF,
	localparam int AW = $clog2(DELAY_DEPTH)
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sdpl_pkg::lane_ctl_t          ctl,
	input  wire  signed [15:0]           sample,
	input  wire         [15:0]           volume,
	input  wire         [AW-1:0]         wr_addr,
	input  wire         [AW-1:0]         rd_addr,
	input  wire         [24:0]           gain,
	output logic signed [15:0]           delayed,
	output logic signed [15:0]           result
);
	import sdpl_pkg::*;

	logic signed [15:0] mem_q [DELAY_DEPTH];
	logic signed [15:0] rdata_q;
	logic               rd_ok_q;
	logic        [32:0] vprod_q;
	logic               vneg_q;
	logic        [41:0] oprod_q;
	logic               oneg_q;

	always_ff @(posedge clk) begin
		if (ctl.scale) begin
			vprod_q <= 33'(mag16(sample)) * 33'(volume);
			vneg_q  <= sample[15];
		end
		if (ctl.outmul) begin
			oprod_q <= 42'(mag16(delayed)) * 42'(gain);
			oneg_q  <= delayed[15];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem_q[wr_addr] <= sat_mag(vneg_q, vprod_q[32:15]);
		end
		if (ctl.read) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else if (ctl.read) begin
			rd_ok_q <= ctl.rd_ok;
		end
	end

	assign delayed = rd_ok_q ? rdata_q : 16'sd0;
	assign result  = sat_mag(oneg_q, oprod_q[41:24]);

endmodule

`default_nettype wire

### rtl/sdpl_gain.sv
// Merge stage: shared peak detect, serial threshold/peak divider and gain smoothing.
// Depends on sdpl_pkg; fed with the delayed samples of both lanes.
`default_nettype none

module sdpl_gain (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  signed [15:0]  left,
	input  wire  signed [15:0]  right,
	input  wire         [14:0]  threshold,
	input  wire         [23:0]  attack,
	input  wire         [23:0]  release_c,
	output logic        [24:0]  gain,
	output logic                done
);
	import sdpl_pkg::*;

	localparam logic [2:0] G_IDLE = 3'd0;
	localparam logic [2:0] G_CMP  = 3'd1;
	localparam logic [2:0] G_DIV  = 3'd2;
	localparam logic [2:0] G_SEL  = 3'd3;
	localparam logic [2:0] G_MLO  = 3'd4;
	localparam logic [2:0] G_MHI  = 3'd5;
	localparam logic [2:0] G_UPD  = 3'd6;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;
	logic [15:0] peak_q;
	logic [14:0] rem_q;
	logic [23:0] quo_q;
	logic [24:0] desired_q;
	logic [24:0] gain_q;
	logic [24:0] diff_q;
	logic [23:0] coeff_q;
	logic        falling_q;
	logic [35:0] plo_q;
	logic [36:0] phi_q;
	logic        done_q;

	logic [16:0] lmag, rmag;
	logic [15:0] trial;
	logic        fit;
	logic        falling;
	logic [48:0] prod_sum;
	logic [24:0] step;

	always_comb begin
		lmag     = mag16(left);
		rmag     = mag16(right);
		trial    = {rem_q, 1'b0};
		fit      = trial >= peak_q;
		falling  = desired_q < gain_q;
		prod_sum = {phi_q, 12'd0} + 49'(plo_q);
		step     = prod_sum[48:24];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			G_IDLE: begin
				if (start) peak_q <= (lmag > rmag) ? lmag[15:0] : rmag[15:0];
			end
			G_CMP: begin
				rem_q     <= threshold;
				quo_q     <= '0;
				desired_q <= UNITY_GAIN;
			end
			G_DIV: begin
				rem_q <= fit ? 15'(trial - peak_q) : trial[14:0];
				quo_q <= {quo_q[22:0], fit};
				if (cnt_q == 5'(DIV_STEPS - 1)) desired_q <= {1'b0, quo_q[22:0], fit};
			end
			G_SEL: begin
				falling_q <= falling;
				coeff_q   <= falling ? attack : release_c;
				diff_q    <= falling ? gain_q - desired_q : desired_q - gain_q;
			end
			G_MLO: plo_q <= 36'(coeff_q) * 36'(diff_q[11:0]);
			G_MHI: phi_q <= 37'(coeff_q) * 37'(diff_q[24:12]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
			gain_q  <= UNITY_GAIN;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == G_UPD);
			case (state_q)
				G_IDLE: if (start) state_q <= G_CMP;
				G_CMP: begin
					cnt_q   <= '0;
					state_q <= (peak_q > {1'b0, threshold}) ? G_DIV : G_SEL;
				end
				G_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DIV_STEPS - 1)) state_q <= G_SEL;
				end
				G_SEL: state_q <= G_MLO;
				G_MLO: state_q <= G_MHI;
				G_MHI: state_q <= G_UPD;
				G_UPD: begin
					// step is truncated toward the target
					gain_q  <= falling_q ? desired_q + step : desired_q - step;
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	assign gain = gain_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY_GAIN) else $error("limiter gain above unity");
	a_rem_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == G_DIV |-> rem_q < peak_q) else $error("divider remainder overflow");
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == G_UPD) else $error("done without gain update");
`endif

endmodule

`default_nettype wire

### rtl/stereo_delay_peak_limiter.sv
// One frame at a time; the 24-step threshold/peak divider runs only when the peak
// of the delayed frame is above the threshold.
// The next frame is accepted once the current one has reached the output register.
// Reset is asynchronous, active low; it restores the register defaults, unity gain
// and an empty delay line (a fill count makes unwritten entries read as zero).
`default_nettype none

module stereo_delay_peak_limiter #(
	parameter int DELAY_DEPTH = sdpl_pkg::DELAY_DEPTH_DEF,
	localparam int AW = $clog2(DELAY_DEPTH)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [15:0]                    left_in,
	input  wire  signed [15:0]                    right_in,
	input  wire                                   frame_last,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [15:0]                    left_out,
	output logic signed [15:0]                    right_out,
	output logic                                  frame_last_out,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire         [sdpl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire         [sdpl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sdpl_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCALE  = 3'd1;
	localparam logic [2:0] S_WRITE  = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_PEAK   = 3'd4;
	localparam logic [2:0] S_WAIT   = 3'd5;
	localparam logic [2:0] S_OUTMUL = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	logic [2:0]          state_q;
	logic [VOL_W-1:0]    volume_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [THR_W-1:0]    thr_q;
	logic [COEFF_W-1:0]  attack_q;
	logic [COEFF_W-1:0]  release_q;
	logic [AW-1:0]       wp_q;
	logic [AW:0]         fill_q;
	logic signed [15:0]  left_q, right_q;
	logic                last_q;
	logic                out_valid_q;
	logic signed [15:0]  left_out_q, right_out_q;
	logic                last_out_q;

	lane_ctl_t           ctl;
	logic [AW-1:0]       d_eff;
	logic [AW-1:0]       rd_addr;
	logic                out_free;
	logic signed [15:0]  l_dly, r_dly, l_res, r_res;
	logic [24:0]         gain;
	logic                gdone;

	always_comb begin
		if ({21'd0, delay_q} > 32'(DELAY_DEPTH - 1)) d_eff = AW'(DELAY_DEPTH - 1);
		else d_eff = AW'(delay_q);
		if (wp_q >= d_eff) rd_addr = wp_q - d_eff;
		else rd_addr = AW'({1'b0, wp_q} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_eff});
		out_free   = !out_valid_q || !out_stall;
		ctl.scale  = state_q == S_SCALE;
		ctl.write  = state_q == S_WRITE;
		ctl.read   = state_q == S_READ;
		ctl.rd_ok  = {1'b0, d_eff} < fill_q;
		ctl.outmul = state_q == S_OUTMUL;
	end

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;

	sdpl_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_l (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(left_q), .volume(volume_q),
		.wr_addr(wp_q), .rd_addr(rd_addr), .gain(gain), .delayed(l_dly), .result(l_res)
	);

	sdpl_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_r (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(right_q), .volume(volume_q),
		.wr_addr(wp_q), .rd_addr(rd_addr), .gain(gain), .delayed(r_dly), .result(r_res)
	);

	sdpl_gain u_gain (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_PEAK), .left(l_dly), .right(r_dly),
		.threshold(thr_q), .attack(attack_q), .release_c(release_q), .gain(gain),
		.done(gdone)
	);

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			left_q  <= left_in;
			right_q <= right_in;
			last_q  <= frame_last;
		end
		if (state_q == S_OUT && out_free) begin
			left_out_q  <= l_res;
			right_out_q <= r_res;
			last_out_q  <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q  <= VOLUME_RST;
			delay_q   <= DELAY_RST;
			thr_q     <= THR_RST;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VOLUME:    volume_q  <= cfg_data[VOL_W-1:0];
				REG_DELAY:     delay_q   <= cfg_data[DELAY_W-1:0];
				REG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				REG_ATTACK:    attack_q  <= cfg_data[COEFF_W-1:0];
				REG_RELEASE:   release_q <= cfg_data[COEFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_SCALE;
				S_SCALE: state_q <= S_WRITE;
				S_WRITE: begin
					if (fill_q != (AW+1)'(DELAY_DEPTH)) fill_q <= fill_q + (AW+1)'(1);
					state_q <= S_READ;
				end
				S_READ: begin
					// advance the ring after the read of this frame
					wp_q    <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
					state_q <= S_PEAK;
				end
				S_PEAK:   state_q <= S_WAIT;
				S_WAIT:   if (gdone) state_q <= S_OUTMUL;
				S_OUTMUL: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign left_out       = left_out_q;
	assign right_out      = right_out_q;
	assign frame_last_out = last_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(DELAY_DEPTH)) else $error("fill count beyond depth");
	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} < (AW+1)'(DELAY_DEPTH)) else $error("write position beyond depth");
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		gdone |-> state_q == S_WAIT) else $error("gain done outside wait");
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT) else $error("result without sequence");
`endif

endmodule

`default_nettype wire

### tb/sdpl_checker.sv
// Scoreboard for the stereo delay peak limiter: watches the frame, result and register
// channels, predicts every output frame and compares it field by field.
// Depends on sdpl_pkg for register indexes, widths and reset values.
module sdpl_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire                                 in_stall,
	input  wire signed [15:0]                   left_in,
	input  wire signed [15:0]                   right_in,
	input  wire                                 frame_last,
	input  wire                                 out_valid,
	input  wire                                 out_stall,
	input  wire signed [15:0]                   left_out,
	input  wire signed [15:0]                   right_out,
	input  wire                                 frame_last_out,
	input  wire                                 cfg_valid,
	input  wire                                 cfg_ready,
	input  wire [sdpl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [sdpl_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  mismatches,
	output int                                  frames_pending,
	output int                                  frames_checked
);
	import sdpl_pkg::*;

	localparam int LINE_DEPTH = DELAY_DEPTH_DEF;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
	} frame_t;

	frame_t limited_frames[$];
	frame_t want;

	longint volume_q15;
	longint threshold;
	longint attack_k;
	longint release_k;
	int     delay_frames;
	int     wr_pos;
	longint gain_q24;
	int     clr;

	logic signed [15:0] left_line [LINE_DEPTH];
	logic signed [15:0] right_line [LINE_DEPTH];

	// Multiply by a nonnegative factor and shift, truncating toward zero.
	function automatic longint mul_trunc(input longint x, input longint k, input int sh);
		longint m;
		m = (x < 0) ? -x : x;
		m = (m * k) >> sh;
		return (x < 0) ? -m : m;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic frame_t limit_frame(input logic signed [15:0] l_in,
		input logic signed [15:0] r_in, input logic last);
		frame_t f;
		int     d;
		int     rd;
		longint dl;
		longint dr;
		longint peak;
		longint target;
		longint coeff;
		longint diff;
		d = (delay_frames > LINE_DEPTH - 1) ? LINE_DEPTH - 1 : delay_frames;
		left_line[wr_pos] = clamp16(mul_trunc(l_in, volume_q15, 15));
		right_line[wr_pos] = clamp16(mul_trunc(r_in, volume_q15, 15));
		// read after write, so a zero delay returns the frame just stored
		rd = (wr_pos + LINE_DEPTH - d) % LINE_DEPTH;
		dl = left_line[rd];
		dr = right_line[rd];
		wr_pos = (wr_pos + 1) % LINE_DEPTH;

		peak = (dl < 0) ? -dl : dl;
		if (((dr < 0) ? -dr : dr) > peak)
			peak = (dr < 0) ? -dr : dr;
		target = longint'(UNITY_GAIN);
		if (peak > threshold && peak > 0)
			target = (threshold << 24) / peak;

		coeff = (target < gain_q24) ? attack_k : release_k;
		if (gain_q24 >= target) begin
			diff = gain_q24 - target;
			gain_q24 = target + ((coeff * diff) >> 24);
		end else begin
			diff = target - gain_q24;
			gain_q24 = target - ((coeff * diff) >> 24);
		end

		f.left = clamp16(mul_trunc(dl, gain_q24, 24));
		f.right = clamp16(mul_trunc(dr, gain_q24, 24));
		f.last = last;
		return f;
	endfunction

	task automatic report(input string msg);
		$display("MISMATCH at output frame %0d: %s", frames_checked, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q15 = VOLUME_RST;
			delay_frames = DELAY_RST;
			threshold = THR_RST;
			attack_k = ATTACK_RST;
			release_k = RELEASE_RST;
			gain_q24 = longint'(UNITY_GAIN);
			wr_pos = 0;
			for (clr = 0; clr < LINE_DEPTH; clr++) begin
				left_line[clr] = '0;
				right_line[clr] = '0;
			end
			limited_frames.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_VOLUME:    volume_q15 = cfg_data[VOL_W-1:0];
					REG_DELAY:     delay_frames = cfg_data[DELAY_W-1:0];
					REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
					REG_ATTACK:    attack_k = cfg_data[COEFF_W-1:0];
					REG_RELEASE:   release_k = cfg_data[COEFF_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (limited_frames.size() == 0) begin
					report($sformatf("result beat (%0d, %0d, %0d) with no frame pending",
						left_out, right_out, frame_last_out));
				end else begin
					want = limited_frames.pop_front();
					if (left_out !== want.left)
						report($sformatf("left_out %0d, predicted %0d", left_out, want.left));
					if (right_out !== want.right)
						report($sformatf("right_out %0d, predicted %0d", right_out, want.right));
					if (frame_last_out !== want.last)
						report($sformatf("frame_last_out %0b, predicted %0b",
							frame_last_out, want.last));
				end
				frames_checked++;
			end
			if (in_valid && !in_stall)
				limited_frames.push_back(limit_frame(left_in, right_in, frame_last));
		end
		frames_pending = limited_frames.size();
	end

endmodule

### tb/tb_top.sv
// Top of the stereo delay peak limiter testbench: clock, reset, frame and register
// stimulus, receiver back-pressure and the verdict. Depends on sdpl_pkg, the block
// and the sdpl_checker scoreboard.
module tb_top;
	import sdpl_pkg::*;

	localparam int LIMIT_CYCLES   = 1000000;
	localparam int SETTING_RUNS   = 12;
	localparam int FRAMES_PER_RUN = 152;
	localparam int IDLE_HOLD      = 40;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_RELEASE + 1'b1;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic signed [15:0]    left_in = '0;
	logic signed [15:0]    right_in = '0;
	logic                  frame_last = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [15:0]    left_out;
	logic signed [15:0]    right_out;
	logic                  frame_last_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int frames_pending;
	int frames_checked;
	int cycle_count = 0;
	int frames_sent = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int gap_max = 0;

	rx_mode_t   stall_mode = RX_FREE;
	int         stall_left = 0;
	logic [7:0] stall_bits = '0;

	stereo_delay_peak_limiter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.left_in        (left_in),
		.right_in       (right_in),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.left_out       (left_out),
		.right_out      (right_out),
		.frame_last_out (frame_last_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	sdpl_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.left_in        (left_in),
		.right_in       (right_in),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.left_out       (left_out),
		.right_out      (right_out),
		.frame_last_out (frame_last_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.frames_pending (frames_pending),
		.frames_checked (frames_checked)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver back-pressure: switch between free, light, heavy and a rotating pattern.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(0, 3));
			stall_bits = 8'($urandom) & 8'h7f;
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			RX_FREE:  out_stall = 1'b0;
			RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
			default: begin
				out_stall = stall_bits[0];
				stall_bits = {stall_bits[0], stall_bits[7:1]};
			end
		endcase
	end

	task automatic wait_drained();
		in_valid = 1'b0;
		while (frames_pending != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		repeat (IDLE_HOLD) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	// Hold valid across a burst; drop it for a random gap when the burst runs out.
	task automatic send_frame(input logic signed [15:0] l, input logic signed [15:0] r,
		input logic last);
		in_valid = 1'b1;
		left_in = l;
		right_in = r;
		frame_last = last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		frames_sent++;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	function automatic logic signed [15:0] draw_sample(input int loud_pct);
		logic signed [15:0] v;
		if ($urandom_range(0, 99) < loud_pct) begin
			v = 16'($urandom_range(20000, 32767));
			if ($urandom_range(0, 1))
				v = -v - 16'sd1;
		end else begin
			case ($urandom_range(0, 2))
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(0, 2000)) - 16'sd1000;
				default: begin
					case ($urandom_range(0, 3))
						0: v = 16'sh7fff;
						1: v = 16'sh8000;
						2: v = 16'sh8001;
						default: v = '0;
					endcase
				end
			endcase
		end
		return v;
	endfunction

	// Pick a register value, now and then with junk above the register width.
	function automatic logic [CFG_DATA_W-1:0] draw_setting(input logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] v;
		logic [CFG_DATA_W-1:0] keep;
		int sel;
		sel = $urandom_range(0, 4);
		case (idx)
			REG_VOLUME: begin
				keep = CFG_DATA_W'((1 << VOL_W) - 1);
				case (sel)
					0: v = '0;
					1: v = 24'd32768;
					2: v = CFG_DATA_W'($urandom_range(40000, 65535));
					default: v = CFG_DATA_W'($urandom_range(8000, 32768));
				endcase
			end
			REG_DELAY: begin
				keep = CFG_DATA_W'((1 << DELAY_W) - 1);
				case (sel)
					0: v = '0;
					1: v = 24'd2047;
					2: v = CFG_DATA_W'($urandom_range(1, 8));
					default: v = CFG_DATA_W'($urandom_range(0, 2047));
				endcase
			end
			REG_THRESHOLD: begin
				keep = CFG_DATA_W'((1 << THR_W) - 1);
				case (sel)
					0: v = '0;
					1: v = 24'd32767;
					2: v = CFG_DATA_W'($urandom_range(1, 200));
					default: v = CFG_DATA_W'($urandom_range(4000, 32767));
				endcase
			end
			default: begin
				keep = '1;
				case (sel)
					0: v = '0;
					1: v = '1;
					2: v = CFG_DATA_W'($urandom_range(15000000, 16777215));
					default: v = CFG_DATA_W'($urandom);
				endcase
			end
		endcase
		if ($urandom_range(0, 2) == 0)
			v = v | (CFG_DATA_W'($urandom) & ~keep);
		return v;
	endfunction

	initial begin
		int run;
		int n;
		int idx;
		int loud_pct;
		logic [CFG_DATA_W-1:0] val;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: full-scale extremes stay under the threshold after volume.
		gap_max = 6;
		send_frame(16'sh7fff, 16'sh8000, 1'b1);
		send_frame(16'sh8000, 16'sh7fff, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b1);
		send_frame(-16'sd1, 16'sd1, 1'b0);
		send_frame(16'sh8000, 16'sh8000, 1'b1);

		// Volume above unity: stored samples saturate and the limiter engages.
		write_register(REG_VOLUME, 24'hffffff);
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sd12345, 1'b1);
		send_frame(16'sd1000, -16'sd1000, 1'b0);

		// Zero threshold with zero coefficients: the gain jumps to its target.
		write_register(REG_THRESHOLD, '0);
		write_register(REG_ATTACK, '0);
		write_register(REG_RELEASE, '0);
		send_frame(16'sd5, -16'sd3, 1'b1);
		send_frame(16'sh0000, 16'sh0000, 1'b0);
		send_frame(-16'sd20000, 16'sd3, 1'b0);

		// Indexes past the last register must be dropped.
		for (idx = REG_FIRST_UNUSED; idx < 2 ** CFG_IDX_W; idx++)
			write_register(CFG_IDX_W'(idx), '0);

		// Longest delay, top threshold, slowest smoothing, unity volume.
		write_register(REG_DELAY, 24'd2047);
		write_register(REG_THRESHOLD, 24'd32767);
		write_register(REG_ATTACK, '1);
		write_register(REG_RELEASE, '1);
		write_register(REG_VOLUME, 24'd32768);
		send_frame(16'sh7fff, 16'sh8000, 1'b1);
		send_frame(16'sd77, -16'sd77, 1'b0);
		send_frame(16'sh8000, 16'sh0001, 1'b1);

		write_register(REG_VOLUME, '0);
		send_frame(16'sh7fff, 16'sh8000, 1'b0);
		send_frame(16'sh8000, 16'sh7fff, 1'b1);

		write_register(REG_DELAY, 24'd1);
		send_frame(16'sd1234, -16'sd4321, 1'b0);
		send_frame(16'sh7fff, 16'sh8000, 1'b1);

		// Random material under a series of settings, first all maxima, then all zeros.
		for (run = 0; run < SETTING_RUNS; run++) begin
			for (idx = REG_VOLUME; idx <= REG_RELEASE; idx++) begin
				if (run == 0)
					val = '1;
				else if (run == 1)
					val = '0;
				else
					val = draw_setting(CFG_IDX_W'(idx));
				write_register(CFG_IDX_W'(idx), val);
			end
			if ($urandom_range(0, 3) == 0)
				write_register(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 2 ** CFG_IDX_W - 1)),
					CFG_DATA_W'($urandom));
			gap_max = (run % 3 == 1) ? 0 : ($urandom_range(0, 1) ? 4 : 45);
			burst_left = $urandom_range(0, 12);
			loud_pct = $urandom_range(0, 90);
			for (n = 0; n < FRAMES_PER_RUN; n++) begin
				// Hold off once mid-run until every predicted frame is out.
				if (run == 4 && n == FRAMES_PER_RUN / 2)
					wait_drained();
				send_frame(draw_sample(loud_pct), draw_sample(loud_pct),
					$urandom_range(0, 7) == 0);
			end
		end

		wait_drained();
		repeat (IDLE_HOLD) @(negedge clk);

		$display("%0d frames sent, %0d limited frames checked, %0d register writes",
			frames_sent, frames_checked, reg_writes);
		$display("covered %0d register settings after the directed corner cases",
			SETTING_RUNS);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### stereo_delay_peak_limiter.f
rtl/sdpl_pkg.sv
rtl/sdpl_lane.sv
rtl/sdpl_gain.sv
rtl/stereo_delay_peak_limiter.sv
tb/sdpl_checker.sv
tb/tb_top.sv
